>>> rtl/ipv4f_pkg.sv
// Shared types, constants and digit helpers for the dotted-quad formatter.
package ipv4f_pkg;

	localparam logic [5:0] CHAR_ZERO = 6'd48;
	localparam logic [5:0] CHAR_DOT  = 6'd46;
	localparam logic [3:0] DOT_COUNT = 4'd3;
	localparam logic [1:0] LAST_OCTET = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_HUND,
		PH_TENS,
		PH_ONES,
		PH_DOT
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	// Decimal digits of one octet; tens by reciprocal multiply (exact below 100).
	function automatic digits_t octet_digits(input logic [7:0] v);
		digits_t    d;
		logic [7:0] r;
		logic [14:0] p;
		logic [7:0] t10;
		if (v >= 8'd200) begin
			d.hund = 4'd2;
			r      = v - 8'd200;
		end else if (v >= 8'd100) begin
			d.hund = 4'd1;
			r      = v - 8'd100;
		end else begin
			d.hund = 4'd0;
			r      = v;
		end
		p      = 15'({8'd0, r[6:0]} * 15'd205);
		d.tens = p[14:11];
		t10    = {1'b0, d.tens, 3'd0} + {3'd0, d.tens, 1'b0};
		d.ones = 4'(r - t10);
		return d;
	endfunction

	// Printed digit count of one octet.
	function automatic logic [1:0] octet_width(input logic [7:0] v);
		logic [1:0] w;
		if (v >= 8'd100) begin
			w = 2'd3;
		end else if (v >= 8'd10) begin
			w = 2'd2;
		end else begin
			w = 2'd1;
		end
		return w;
	endfunction

	// First digit phase of an octet (no leading zeros).
	function automatic phase_t first_phase(input logic [7:0] v);
		phase_t ph;
		if (v >= 8'd100) begin
			ph = PH_HUND;
		end else if (v >= 8'd10) begin
			ph = PH_TENS;
		end else begin
			ph = PH_ONES;
		end
		return ph;
	endfunction

endpackage

>>> rtl/ipv4f_ctrl.sv
// Controller state machine: sequences load and one character step per cycle.
module ipv4f_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output ipv4f_pkg::dp_cmd_t   cmd,
	input  ipv4f_pkg::dp_status_t status
);

	ipv4f_pkg::ctrl_state_t state_q, state_d;
	logic accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv4f_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipv4f_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ipv4f_pkg::ST_RUN;
				end
			end
			ipv4f_pkg::ST_RUN: begin
				if (status.last && !accept) begin
					state_d = ipv4f_pkg::ST_IDLE;
				end
			end
			default: state_d = ipv4f_pkg::ST_IDLE;
		endcase
	end

	// next item may be taken on the cycle the last character is generated
	always_comb begin
		busy = 1'b0;
		cmd  = '0;
		unique case (state_q)
			ipv4f_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.step = 1'b0;
			end
			ipv4f_pkg::ST_RUN: begin
				busy     = !status.last;
				cmd.step = 1'b1;
			end
			default: begin
				busy     = 1'b0;
				cmd.step = 1'b0;
			end
		endcase
		cmd.load = accept;
	end

endmodule

>>> rtl/ipv4f_datapath.sv
// Datapath: address and length registers, octet/digit position, output register.
module ipv4f_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           ip_address,
	input  ipv4f_pkg::dp_cmd_t    cmd,
	output ipv4f_pkg::dp_status_t status,
	output logic                  strobe,
	output logic [5:0]            text_char,
	output logic                  is_last,
	output logic [3:0]            text_length
);

	logic [31:0]       addr_q;
	logic [3:0]        len_q;
	logic [1:0]        oct_q;
	ipv4f_pkg::phase_t phase_q;
	logic              strobe_q;
	logic [5:0]        char_q;
	logic              last_q;
	logic [3:0]        len_out_q;

	logic [7:0]        cur_oct;
	logic [7:0]        nxt_oct;
	logic [1:0]        oct_nxt;
	ipv4f_pkg::digits_t dig;
	logic [5:0]        cur_char;
	logic              cur_last;
	logic [3:0]        load_len;
	ipv4f_pkg::phase_t phase_nxt;

	assign oct_nxt = oct_q + 2'd1;
	assign cur_oct = addr_q[{oct_q, 3'd0} +: 8];
	assign nxt_oct = addr_q[{oct_nxt, 3'd0} +: 8];
	assign dig     = ipv4f_pkg::octet_digits(cur_oct);

	assign load_len = ipv4f_pkg::DOT_COUNT
		+ {2'd0, ipv4f_pkg::octet_width(ip_address[7:0])}
		+ {2'd0, ipv4f_pkg::octet_width(ip_address[15:8])}
		+ {2'd0, ipv4f_pkg::octet_width(ip_address[23:16])}
		+ {2'd0, ipv4f_pkg::octet_width(ip_address[31:24])};

	assign cur_last = (phase_q == ipv4f_pkg::PH_ONES) && (oct_q == ipv4f_pkg::LAST_OCTET);
	assign status.last = cur_last;

	always_comb begin
		cur_char  = ipv4f_pkg::CHAR_DOT;
		phase_nxt = phase_q;
		unique case (phase_q)
			ipv4f_pkg::PH_HUND: begin
				cur_char  = ipv4f_pkg::CHAR_ZERO + {2'd0, dig.hund};
				phase_nxt = ipv4f_pkg::PH_TENS;
			end
			ipv4f_pkg::PH_TENS: begin
				cur_char  = ipv4f_pkg::CHAR_ZERO + {2'd0, dig.tens};
				phase_nxt = ipv4f_pkg::PH_ONES;
			end
			ipv4f_pkg::PH_ONES: begin
				cur_char  = ipv4f_pkg::CHAR_ZERO + {2'd0, dig.ones};
				phase_nxt = ipv4f_pkg::PH_DOT;
			end
			ipv4f_pkg::PH_DOT: begin
				cur_char  = ipv4f_pkg::CHAR_DOT;
				phase_nxt = ipv4f_pkg::first_phase(nxt_oct);
			end
			default: begin
				cur_char  = ipv4f_pkg::CHAR_DOT;
				phase_nxt = ipv4f_pkg::PH_ONES;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q    <= 2'd0;
			phase_q  <= ipv4f_pkg::PH_ONES;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
			if (cmd.load) begin
				oct_q   <= 2'd0;
				phase_q <= ipv4f_pkg::first_phase(ip_address[7:0]);
			end else if (cmd.step) begin
				phase_q <= phase_nxt;
				if (phase_q == ipv4f_pkg::PH_DOT) begin
					oct_q <= oct_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= ip_address;
			len_q  <= load_len;
		end
		if (cmd.step) begin
			char_q    <= cur_char;
			last_q    <= cur_last;
			len_out_q <= len_q;
		end
	end

	assign strobe      = strobe_q;
	assign text_char   = char_q;
	assign is_last     = last_q;
	assign text_length = len_out_q;

endmodule

>>> rtl/ipv4_dotted_quad_formatter_unit.sv
// Top level of the IPv4 dotted-quad formatter.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------
//  input     start / busy       ip_address[31:0]
//  result    strobe             text_char[5:0] is_last text_length[3:0]
//
// One item gives 7 to 15 characters, one per cycle from the digit sequencer;
// the first is produced after the load is registered, then captured in the
// output register. A new item is taken on the cycle the previous last character
// is generated, so items follow without a gap. Results are not held off by the
// receiver. Reset clears the sequencer and the strobe; no result follows reset.
module ipv4_dotted_quad_formatter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] ip_address,
	output logic        strobe,
	output logic [5:0]  text_char,
	output logic        is_last,
	output logic [3:0]  text_length
);

	ipv4f_pkg::dp_cmd_t    cmd;
	ipv4f_pkg::dp_status_t status;

	ipv4f_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	ipv4f_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ip_address  (ip_address),
		.cmd         (cmd),
		.status      (status),
		.strobe      (strobe),
		.text_char   (text_char),
		.is_last     (is_last),
		.text_length (text_length)
	);

endmodule

>>> rtl/ipv4f_checker.sv
// Port-level checks for the dotted-quad formatter, bound to the top level.
module ipv4f_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [5:0]  text_char,
	input logic        is_last,
	input logic [3:0]  text_length
);

	// characters of one item come out in an unbroken run
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> strobe)
		else $error("character run broken");

	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |=> text_length == $past(text_length))
		else $error("length changed within an item");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (text_length >= 4'd7) && (text_length <= 4'd15))
		else $error("length out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("not busy after an item was taken");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (text_char == 6'd46) || ((text_char >= 6'd48) && (text_char <= 6'd57)))
		else $error("illegal character");

endmodule

bind ipv4_dotted_quad_formatter_unit ipv4f_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.text_char   (text_char),
	.is_last     (is_last),
	.text_length (text_length)
);

>>> test/tb_ipv4_dotted_quad_formatter_unit.sv
// Testbench for the dotted-quad formatter: directed table, then random addresses, char-by-char checks.
module tb_ipv4_dotted_quad_formatter_unit;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int RANDOM_ITEMS = 160;
	localparam int SETTLE       = 8;

	typedef struct packed {
		logic [5:0] text_char;
		logic       is_last;
		logic [3:0] text_length;
	} text_char_t;

	typedef struct {
		logic [31:0] addr;
		string       text;
	} addr_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [31:0] ip_address  = 32'd0;
	logic        busy;
	logic        strobe;
	logic [5:0]  text_char;
	logic        is_last;
	logic [3:0]  text_length;

	text_char_t  pending_chars [$];
	text_char_t  want_char;
	int          mismatches = 0;
	int          cycles     = 0;
	int          burst_left = 0;

	// empty text: expectation comes from format_address
	addr_row_t directed_rows [18] = '{
		'{32'h0000_0000, "0.0.0.0"},
		'{32'hFFFF_FFFF, "255.255.255.255"},
		'{32'h0000_00FF, "255.0.0.0"},
		'{32'hFF00_0000, "0.0.0.255"},
		'{32'h0403_0201, "1.2.3.4"},
		'{32'h0909_0909, ""},
		'{32'h0A0A_0A0A, ""},
		'{32'h6363_6363, ""},
		'{32'h6464_6464, ""},
		'{32'hC7C8_C9CA, ""},
		'{32'hAAAA_AAAA, ""},
		'{32'h5555_5555, ""},
		'{32'h00FF_00FF, ""},
		'{32'h6400_000A, ""},
		'{32'hF9FA_FBFC, ""},
		'{32'h0A63_6409, ""},
		'{32'h8000_0001, ""},
		'{32'h0102_0304, ""}
	};

	ipv4_dotted_quad_formatter_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.ip_address  (ip_address),
		.strobe      (strobe),
		.text_char   (text_char),
		.is_last     (is_last),
		.text_length (text_length)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycles, msg);
		mismatches++;
	endtask

	// Dotted-decimal text of one address, lowest octet first.
	task automatic format_address(input logic [31:0] addr);
		logic [5:0] chars [15];
		int         len;
		int         octet;
		text_char_t c;
		len = 0;
		for (int k = 0; k < 4; k++) begin
			octet = int'(addr[8*k +: 8]);
			if (k != 0) begin
				chars[len] = 6'd46;
				len++;
			end
			if (octet >= 100) begin
				chars[len] = 6'(48 + octet / 100);
				len++;
			end
			if (octet >= 10) begin
				chars[len] = 6'(48 + (octet / 10) % 10);
				len++;
			end
			chars[len] = 6'(48 + octet % 10);
			len++;
		end
		for (int k = 0; k < len; k++) begin
			c.text_char   = chars[k];
			c.is_last     = (k == len - 1);
			c.text_length = 4'(len);
			pending_chars.push_back(c);
		end
	endtask

	task automatic queue_typed_text(input string s);
		text_char_t c;
		for (int k = 0; k < s.len(); k++) begin
			c.text_char   = 6'(s[k]);
			c.is_last     = (k == s.len() - 1);
			c.text_length = 4'(s.len());
			pending_chars.push_back(c);
		end
	endtask

	// Returns at the edge where the item was taken.
	task automatic send_address(input logic [31:0] addr);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
				: $urandom_range(1, 8);
		end
		start      <= 1'b1;
		ip_address <= addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
	endtask

	task automatic drain_text;
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_octet;
		logic [7:0] v;
		case ($urandom_range(0, 5))
			0: v = 8'($urandom_range(0, 9));
			1: v = 8'($urandom_range(10, 99));
			2: v = 8'($urandom_range(100, 255));
			3: begin
				case ($urandom_range(0, 7))
					0: v = 8'd0;
					1: v = 8'd9;
					2: v = 8'd10;
					3: v = 8'd99;
					4: v = 8'd100;
					5: v = 8'd199;
					6: v = 8'd200;
					default: v = 8'd255;
				endcase
			end
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected char %0d", text_char));
			end else begin
				want_char = pending_chars.pop_front();
				if (text_char !== want_char.text_char)
					note_mismatch($sformatf("text_char got %0d want %0d",
						text_char, want_char.text_char));
				if (is_last !== want_char.is_last)
					note_mismatch($sformatf("is_last got %b want %b",
						is_last, want_char.is_last));
				if (text_length !== want_char.text_length)
					note_mismatch($sformatf("text_length got %0d want %0d",
						text_length, want_char.text_length));
			end
		end
	end

	initial begin
		logic [31:0] addr;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_address(directed_rows[i].addr);
			if (directed_rows[i].text.len() != 0)
				queue_typed_text(directed_rows[i].text);
			else
				format_address(directed_rows[i].addr);
		end
		drain_text();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 3) == 0)
				addr = $urandom;
			else
				addr = {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
			send_address(addr);
			format_address(addr);
			if (n == RANDOM_ITEMS / 2)
				drain_text();
		end

		drain_text();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
